// ===== rtl/core/sbr_pkg.sv =====
// Shared types, constants and step functions for the radiative boundary pipeline.
package sbr_pkg;

  localparam int GRID_X_DEF        = 16;
  localparam int GRID_Y_DEF        = 16;
  localparam int GRID_Z_DEF        = 16;
  localparam int PAD_WIDTH_DEF     = 3;
  localparam int ZERO_BOUNDARY_DEF = 0;

  localparam int S_W    = 50;  // exact sum of four floored products
  localparam int R2_W   = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 36;
  localparam int Q_W    = 32;

  typedef enum logic [2:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_ORIGIN_Z  = 3'd2,
    REG_STEP_X    = 3'd3,
    REG_STEP_Y    = 3'd4,
    REG_STEP_Z    = 3'd5,
    REG_FALLOFF   = 3'd6,
    REG_FACE_MASK = 3'd7
  } reg_addr_t;

  typedef struct packed {
    logic           flag;
    logic           zero;
    logic           sgn;
    logic [S_W-1:0] mag;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [R2_W-1:0]   n;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic              flag;
    logic              zero;
    logic              sgn;
    logic              ovf;
    logic [ROOT_W-1:0] r;
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    dvd;
    logic [Q_W-1:0]    q;
  } div_t;

  // one digit of the square root
  function automatic sqrt_t sqrt_step(sqrt_t a);
    sqrt_t             o;
    logic [ROOT_W-1:0] root_s;
    logic [REM_W-1:0]  rem_s;
    logic [REM_W-1:0]  trial;
    o      = a;
    root_s = {a.root[ROOT_W-2:0], 1'b0};
    rem_s  = {a.rem[REM_W-3:0], a.n[R2_W-1 -: 2]};
    trial  = {3'b000, root_s, 1'b1};
    o.n    = {a.n[R2_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      o.rem  = rem_s - trial;
      o.root = root_s | ROOT_W'(1);
    end else begin
      o.rem  = rem_s;
      o.root = root_s;
    end
    return o;
  endfunction

  // one quotient bit of the restoring divider
  function automatic div_t div_step(div_t a);
    div_t            o;
    logic [ROOT_W:0] rem2;
    logic [ROOT_W:0] r33;
    logic            ge;
    o     = a;
    rem2  = {a.rem, a.dvd[Q_W-1]};
    r33   = {1'b0, a.r};
    ge    = (rem2 >= r33);
    o.rem = ge ? ROOT_W'(rem2 - r33) : rem2[ROOT_W-1:0];
    o.q   = {a.q[Q_W-2:0], ge};
    o.dvd = {a.dvd[Q_W-2:0], 1'b0};
    return o;
  endfunction

endpackage

// ===== rtl/core/sommerfeld_boundary_rhs.sv =====
// Stages: front, root digits, overflow check, quotient bits, then an output register.
// Throughput: one request per cycle while the output is not stalled.
// A stall on the output holds the whole pipeline; bubbles stay in place while stalled.
// Reset (synchronous, active high) clears all valid bits and sets the registers:
// origins 0, steps 1.0, falloff 1.0, face mask 0.
module sommerfeld_boundary_rhs #(
  parameter int GRID_X        = sbr_pkg::GRID_X_DEF,
  parameter int GRID_Y        = sbr_pkg::GRID_Y_DEF,
  parameter int GRID_Z        = sbr_pkg::GRID_Z_DEF,
  parameter int PAD_WIDTH     = sbr_pkg::PAD_WIDTH_DEF,
  parameter int ZERO_BOUNDARY = sbr_pkg::ZERO_BOUNDARY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         index_x,
  input  logic [3:0]         index_y,
  input  logic [3:0]         index_z,
  input  logic signed [31:0] field_value,
  input  logic signed [31:0] deriv_x,
  input  logic signed [31:0] deriv_y,
  input  logic signed [31:0] deriv_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] rhs_value,
  output logic               write_flag
);

  logic signed [31:0] origin_x, origin_y, origin_z;
  logic [30:0]        step_x, step_y, step_z;
  logic [23:0]        falloff;
  logic [5:0]         face_mask;
  sbr_pkg::reg_addr_t addr;
  logic               en;

  sbr_pkg::side_t                 f_side, s_side;
  logic [sbr_pkg::R2_W-1:0]       r2;
  logic [sbr_pkg::ROOT_W-1:0]     root;
  logic                           f_valid, s_valid, d_valid;
  sbr_pkg::div_t                  dres;
  logic signed [31:0]             rhs_next;

  assign addr     = sbr_pkg::reg_addr_t'(paddr[4:2]);
  assign pready   = 1'b1;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      step_x    <= 31'd65536;
      step_y    <= 31'd65536;
      step_z    <= 31'd65536;
      falloff   <= 24'd65536;
      face_mask <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (addr)
        sbr_pkg::REG_ORIGIN_X:  origin_x  <= pwdata;
        sbr_pkg::REG_ORIGIN_Y:  origin_y  <= pwdata;
        sbr_pkg::REG_ORIGIN_Z:  origin_z  <= pwdata;
        sbr_pkg::REG_STEP_X:    step_x    <= pwdata[30:0];
        sbr_pkg::REG_STEP_Y:    step_y    <= pwdata[30:0];
        sbr_pkg::REG_STEP_Z:    step_z    <= pwdata[30:0];
        sbr_pkg::REG_FALLOFF:   falloff   <= pwdata[23:0];
        sbr_pkg::REG_FACE_MASK: face_mask <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      sbr_pkg::REG_ORIGIN_X:  prdata = origin_x;
      sbr_pkg::REG_ORIGIN_Y:  prdata = origin_y;
      sbr_pkg::REG_ORIGIN_Z:  prdata = origin_z;
      sbr_pkg::REG_STEP_X:    prdata = {1'b0, step_x};
      sbr_pkg::REG_STEP_Y:    prdata = {1'b0, step_y};
      sbr_pkg::REG_STEP_Z:    prdata = {1'b0, step_z};
      sbr_pkg::REG_FALLOFF:   prdata = {8'h00, falloff};
      sbr_pkg::REG_FACE_MASK: prdata = {26'h0, face_mask};
      default:                prdata = '0;
    endcase
  end

  sbr_front #(
    .GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z), .PAD_WIDTH(PAD_WIDTH)
  ) u_front (
    .clk, .rst, .en, .in_valid,
    .index_x, .index_y, .index_z, .field_value, .deriv_x, .deriv_y, .deriv_z,
    .origin_x, .origin_y, .origin_z, .step_x, .step_y, .step_z, .falloff, .face_mask,
    .out_valid(f_valid), .side(f_side), .r2
  );

  sbr_sqrt u_sqrt (
    .clk, .rst, .en, .in_valid(f_valid), .in_side(f_side), .r2,
    .out_valid(s_valid), .out_side(s_side), .root
  );

  sbr_div u_div (
    .clk, .rst, .en, .in_valid(s_valid), .in_side(s_side), .root,
    .out_valid(d_valid), .res(dres)
  );

  // sign and saturation; r = 0 shows up as overflow
  always_comb begin
    if (!dres.flag || ZERO_BOUNDARY != 0 || dres.zero) begin
      rhs_next = '0;
    end else if (!dres.sgn) begin
      if (dres.ovf || dres.q > 32'h8000_0000) rhs_next = 32'sh8000_0000;
      else                                    rhs_next = -$signed(dres.q);
    end else begin
      if (dres.ovf || dres.q[31])             rhs_next = 32'sh7fff_ffff;
      else                                    rhs_next = $signed(dres.q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rhs_value  <= rhs_next;
      write_flag <= dres.flag;
    end
  end

endmodule

// ===== rtl/core/sbr_front.sv =====
// Coordinates, boundary flag, products and the numerator / radius-squared sums.
module sbr_front #(
  parameter int GRID_X    = sbr_pkg::GRID_X_DEF,
  parameter int GRID_Y    = sbr_pkg::GRID_Y_DEF,
  parameter int GRID_Z    = sbr_pkg::GRID_Z_DEF,
  parameter int PAD_WIDTH = sbr_pkg::PAD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [3:0]                index_x,
  input  logic [3:0]                index_y,
  input  logic [3:0]                index_z,
  input  logic signed [31:0]        field_value,
  input  logic signed [31:0]        deriv_x,
  input  logic signed [31:0]        deriv_y,
  input  logic signed [31:0]        deriv_z,
  input  logic signed [31:0]        origin_x,
  input  logic signed [31:0]        origin_y,
  input  logic signed [31:0]        origin_z,
  input  logic [30:0]               step_x,
  input  logic [30:0]               step_y,
  input  logic [30:0]               step_z,
  input  logic [23:0]               falloff,
  input  logic [5:0]                face_mask,
  output logic                      out_valid,
  output sbr_pkg::side_t            side,
  output logic [sbr_pkg::R2_W-1:0]  r2
);

  localparam int XHI = GRID_X - PAD_WIDTH - 1;
  localparam int YHI = GRID_Y - PAD_WIDTH - 1;
  localparam int ZHI = GRID_Z - PAD_WIDTH - 1;

  function automatic logic signed [31:0] coord(logic signed [31:0] org, logic [3:0] idx,
                                               logic [30:0] stp);
    logic [34:0]        prod;
    logic signed [36:0] sum;
    prod = 35'(idx) * 35'(stp);
    sum  = 37'(org) + $signed({2'b00, prod});
    if (sum[36:31] != {6{sum[36]}})
      return sum[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    return sum[31:0];
  endfunction

  function automatic logic in_rng(logic [3:0] idx, int hi);
    return (int'(idx) >= PAD_WIDTH) && (int'(idx) <= hi);
  endfunction

  function automatic logic on_fc(logic [3:0] idx, int hi, logic lo_en, logic hi_en);
    return (lo_en && int'(idx) == PAD_WIDTH) || (hi_en && int'(idx) == hi);
  endfunction

  logic               flag_next;
  logic [2:0]         vld;
  // stage 1
  logic               flag1;
  logic signed [31:0] cx, cy, cz, f1, dx1, dy1, dz1;
  logic [23:0]        fo1;
  // stage 2
  logic               flag2;
  logic signed [63:0] px, py, pz, qx, qy, qz;
  logic signed [55:0] pf;
  // stage 3 sums
  logic signed [sbr_pkg::S_W-1:0] s_next;

  assign flag_next = in_rng(index_x, XHI) && in_rng(index_y, YHI) && in_rng(index_z, ZHI) &&
                     (on_fc(index_x, XHI, face_mask[0], face_mask[1]) ||
                      on_fc(index_y, YHI, face_mask[2], face_mask[3]) ||
                      on_fc(index_z, ZHI, face_mask[4], face_mask[5]));

  assign s_next = sbr_pkg::S_W'($signed(px[63:16])) + sbr_pkg::S_W'($signed(py[63:16])) +
                  sbr_pkg::S_W'($signed(pz[63:16])) + sbr_pkg::S_W'($signed(pf[55:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flag1 <= flag_next;
      cx    <= coord(origin_x, index_x, step_x);
      cy    <= coord(origin_y, index_y, step_y);
      cz    <= coord(origin_z, index_z, step_z);
      f1    <= field_value;
      dx1   <= deriv_x;
      dy1   <= deriv_y;
      dz1   <= deriv_z;
      fo1   <= falloff;

      flag2 <= flag1;
      px    <= 64'(cx) * 64'(dx1);
      py    <= 64'(cy) * 64'(dy1);
      pz    <= 64'(cz) * 64'(dz1);
      pf    <= 56'($signed({1'b0, fo1})) * 56'(f1);
      qx    <= 64'(cx) * 64'(cx);
      qy    <= 64'(cy) * 64'(cy);
      qz    <= 64'(cz) * 64'(cz);

      side.flag <= flag2;
      side.zero <= (s_next == '0);
      side.sgn  <= s_next[sbr_pkg::S_W-1];
      side.mag  <= s_next[sbr_pkg::S_W-1] ? sbr_pkg::S_W'(-s_next) : sbr_pkg::S_W'(s_next);
      r2        <= 64'(qx) + 64'(qy) + 64'(qz);
    end
  end

  assign out_valid = vld[2];

endmodule

// ===== rtl/core/sbr_sqrt.sv =====
// Square root pipeline: one root digit per stage.
module sbr_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  sbr_pkg::side_t              in_side,
  input  logic [sbr_pkg::R2_W-1:0]    r2,
  output logic                        out_valid,
  output sbr_pkg::side_t              out_side,
  output logic [sbr_pkg::ROOT_W-1:0]  root
);

  localparam int N = sbr_pkg::ROOT_W;

  sbr_pkg::sqrt_t       st [N];
  sbr_pkg::sqrt_t       head;
  logic [N-1:0]         vld;

  always_comb begin
    head.side = in_side;
    head.n    = r2;
    head.rem  = '0;
    head.root = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= sbr_pkg::sqrt_step(head);
      for (int i = 1; i < N; i++) begin
        st[i] <= sbr_pkg::sqrt_step(st[i-1]);
      end
    end
  end

  assign out_valid = vld[N-1];
  assign out_side  = st[N-1].side;
  assign root      = st[N-1].root;

endmodule

// ===== rtl/core/sbr_div.sv =====
// Restoring divider pipeline: overflow check, then one quotient bit per stage.
module sbr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  sbr_pkg::side_t              in_side,
  input  logic [sbr_pkg::ROOT_W-1:0]  root,
  output logic                        out_valid,
  output sbr_pkg::div_t               res
);

  localparam int N = sbr_pkg::Q_W;

  sbr_pkg::div_t st [N+1];
  sbr_pkg::div_t head;
  logic [N:0]    vld;

  // quotient of (mag << 16) / r overflows 32 bits when mag >> 16 >= r
  always_comb begin
    head.flag = in_side.flag;
    head.zero = in_side.zero;
    head.sgn  = in_side.sgn;
    head.ovf  = (in_side.mag[sbr_pkg::S_W-1:16] >= 34'(root));
    head.r    = root;
    head.rem  = in_side.mag[47:16];
    head.dvd  = {in_side.mag[15:0], 16'h0000};
    head.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= head;
      for (int i = 1; i <= N; i++) begin
        st[i] <= sbr_pkg::div_step(st[i-1]);
      end
    end
  end

  assign out_valid = vld[N];
  assign res       = st[N];

endmodule
